@@ rtl/tdbl_pkg.sv @@
// ----------------------------------------------------------------------------
// tdbl_pkg: shared types and constants for the tree distance unit
// Node and distance widths, the command record passed from the front end to
// the engine, and the engine status group.
// ----------------------------------------------------------------------------
package tdbl_pkg;

    localparam int NODE_W        = 10;
    localparam int DIST_W        = 11;
    localparam int NODE_XW       = 21;   // holds any node index count up to 2^20
    localparam int DIST_MAX      = 2047;
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_LEVELS    = 10;

    typedef logic [DIST_W-1:0] dist_t;

    typedef struct packed {
        logic              is_query;
        logic [NODE_W-1:0] a;   // loaded node, or first query node
        logic [NODE_W-1:0] b;   // parent, or second query node
    } cmd_t;

    typedef struct packed {
        logic clearing;   // table clear sweep in progress
        logic cmd_pop;    // engine takes the head command
    } eng_status_t;

endpackage

@@ rtl/tdbl_front.sv @@
// ----------------------------------------------------------------------------
// tdbl_front: input classification and command queue
// Clamps node indices, drops loads that change nothing and queues the rest
// in a two-entry command queue ahead of the engine.
// ----------------------------------------------------------------------------
module tdbl_front
    import tdbl_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              cmd,
    input  logic [NODE_W-1:0] node,
    input  logic [NODE_W-1:0] other_node,
    input  eng_status_t       eng_status,
    output logic              cq_valid,
    output cmd_t              cq_head
);

    cmd_t        q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        node_ok, other_ok, accept, enq, deq;
    cmd_t        item;

    assign node_ok  = ({{(NODE_XW-NODE_W){1'b0}}, node} < NODE_XW'(MAX_NODES));
    assign other_ok = ({{(NODE_XW-NODE_W){1'b0}}, other_node} < NODE_XW'(MAX_NODES));

    always_comb
    begin
        item.is_query = cmd;
        item.a        = node_ok ? node : '0;
        item.b        = other_ok ? other_node : '0;
    end

    assign full   = (cnt_reg == 2'd2) || eng_status.clearing;
    assign accept = push && !full;
    // a load of the sentinel or of an index out of range changes nothing
    assign enq    = accept && (cmd || (node_ok && other_ok && (node != '0)));
    assign deq    = eng_status.cmd_pop && (cnt_reg != 2'd0);

    assign cq_valid = (cnt_reg != 2'd0);
    assign cq_head  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = enq ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, enq} - {1'b0, deq};
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/tdbl_engine.sv @@
// ----------------------------------------------------------------------------
// tdbl_engine: binary lifting sequencer with depth and jump tables
// Clears the tables after reset, builds jump rows for loads one level per
// cycle, and walks queries through a lift pass and a joint pass.
// ----------------------------------------------------------------------------
module tdbl_engine
    import tdbl_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int LEVELS    = DEF_LEVELS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cq_valid,
    input  cmd_t        cq_head,
    output eng_status_t eng_status,
    input  logic        res_full,
    output logic        res_push,
    output dist_t       res_val
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int KW = $clog2(LEVELS);
    localparam int CW = (LEVELS + 2 > DIST_W + 1) ? LEVELS + 2 : DIST_W + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_QDEP  = 3'd3;
    localparam logic [2:0] S_LIFT  = 3'd4;
    localparam logic [2:0] S_JOINT = 3'd5;

    typedef logic [LEVELS-1:0][AW-1:0] row_t;

    row_t              jmem [MAX_NODES];
    logic [LEVELS-1:0] dmem [MAX_NODES];

    row_t              jrow_a_q, jrow_b_q;
    logic [LEVELS-1:0] dep_a_q, dep_b_q;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]     a_reg, a_next, b_reg, b_next, n_reg, n_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [LEVELS-1:0] diff_reg, diff_next, dep_reg, dep_next;
    logic [CW-1:0]     count_reg, count_next, fin;
    row_t              row_reg, row_next, wrow;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [LEVELS-1:0] wdep;
    logic [AW-1:0]     val;
    logic              pop;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        diff_next    = diff_reg;
        dep_next     = dep_reg;
        count_next   = count_reg;
        row_next     = row_reg;
        we           = 1'b0;
        waddr        = n_reg;
        wrow         = row_reg;
        wdep         = dep_reg;
        pop          = 1'b0;
        res_push     = 1'b0;
        res_val      = '0;
        val          = '0;
        fin          = '0;
        case (state_reg)
            S_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_cnt_reg;
                wrow         = '0;
                wdep         = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cq_valid && (!cq_head.is_query || !res_full))
                begin
                    pop    = 1'b1;
                    a_next = AW'(cq_head.a);
                    b_next = AW'(cq_head.b);
                    if (cq_head.is_query)
                    begin
                        state_next = S_QDEP;
                    end
                    else
                    begin
                        n_next      = AW'(cq_head.a);
                        row_next[0] = AW'(cq_head.b);
                        k_next      = KW'(1);
                        state_next  = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                // a jump through the node itself sees the row being built
                val         = (b_reg == n_reg) ? row_reg[k_reg - 1'b1]
                                               : jrow_b_q[k_reg - 1'b1];
                row_next[k_reg] = val;
                b_next      = val;
                if (k_reg == KW'(1))
                begin
                    dep_next = (dep_b_q == '1) ? dep_b_q : dep_b_q + 1'b1;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == KW'(LEVELS - 1))
                begin
                    we         = 1'b1;
                    waddr      = n_reg;
                    wrow       = row_next;
                    wdep       = dep_next;
                    state_next = S_IDLE;
                end
            end
            S_QDEP:
            begin
                if (dep_a_q > dep_b_q)
                begin
                    a_next    = b_reg;
                    b_next    = a_reg;
                    diff_next = dep_a_q - dep_b_q;
                end
                else
                begin
                    diff_next = dep_b_q - dep_a_q;
                end
                count_next = CW'(diff_next);
                k_next     = KW'(LEVELS - 1);
                state_next = S_LIFT;
            end
            S_LIFT:
            begin
                if (diff_reg[k_reg])
                begin
                    b_next = jrow_b_q[k_reg];
                end
                k_next = k_reg - 1'b1;
                if (k_reg == '0)
                begin
                    if (a_reg == b_next)
                    begin
                        res_push   = 1'b1;
                        res_val    = count_reg[DIST_W-1:0];
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = KW'(LEVELS - 1);
                        state_next = S_JOINT;
                    end
                end
            end
            S_JOINT:
            begin
                if (jrow_a_q[k_reg] != jrow_b_q[k_reg])
                begin
                    a_next     = jrow_a_q[k_reg];
                    b_next     = jrow_b_q[k_reg];
                    count_next = count_reg + (CW'(2) << k_reg);
                end
                k_next = k_reg - 1'b1;
                if (k_reg == '0)
                begin
                    fin        = count_next + CW'(2);
                    res_push   = 1'b1;
                    res_val    = (fin > CW'(DIST_MAX)) ? dist_t'(DIST_MAX)
                                                       : fin[DIST_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign eng_status.clearing = (state_reg == S_CLEAR);
    assign eng_status.cmd_pop  = pop;

    // tables: one write port, two registered read ports following a/b
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            jmem[waddr] <= wrow;
            dmem[waddr] <= wdep;
        end
        jrow_a_q <= jmem[a_next];
        jrow_b_q <= jmem[b_next];
        dep_a_q  <= dmem[a_next];
        dep_b_q  <= dmem[b_next];
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        n_reg     <= n_next;
        diff_reg  <= diff_next;
        dep_reg   <= dep_next;
        count_reg <= count_next;
        row_reg   <= row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            k_reg       <= k_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !pop)
        else $error("command taken during clear sweep");

    a_sentinel_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (we && (state_reg == S_LOAD)) |-> (waddr != '0))
        else $error("load wrote the sentinel row");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_query_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QDEP) |=> (state_reg == S_LIFT) && (k_reg == KW'(LEVELS - 1)))
        else $error("query did not enter the lift pass");
`endif

endmodule

@@ rtl/tdbl_result_q.sv @@
// ----------------------------------------------------------------------------
// tdbl_result_q: two-entry result queue
// Holds finished distances until the consumer pops them.
// ----------------------------------------------------------------------------
module tdbl_result_q
    import tdbl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  res_push,
    input  dist_t res_val,
    output logic  res_full,
    input  logic  pop,
    output logic  empty,
    output dist_t distance
);

    dist_t      q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       enq, deq;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign distance = q_mem[rd_ptr_reg];
    assign enq      = res_push && !res_full;
    assign deq      = pop && !empty;

    always_comb
    begin
        wr_ptr_next = enq ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, enq} - {1'b0, deq};
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem[wr_ptr_reg] <= res_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/tree_distance_binary_lifting_unit.sv @@
// ----------------------------------------------------------------------------
// tree_distance_binary_lifting_unit: tree path length by binary lifting
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+------------------------------
//  command   | in  | push / full      | cmd, node, other_node
//  result    | out | empty / pop      | distance (queries only)
//
// A load transaction waits in the command queue, then the engine builds its jump row level by level.
// A query passes through a depth read, a lift pass and a joint pass; the joint
// pass is skipped when the lift pass already lands on the other node.
// After reset the tables are cleared one node per cycle, with full held
// high for the whole sweep. Both sides stall independently behind two-entry
// command and result queues.
// ----------------------------------------------------------------------------
module tree_distance_binary_lifting_unit
    import tdbl_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int LEVELS    = DEF_LEVELS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              cmd,
    input  logic [NODE_W-1:0] node,
    input  logic [NODE_W-1:0] other_node,
    output logic              empty,
    input  logic              pop,
    output logic [DIST_W-1:0] distance
);

    eng_status_t eng_status;
    logic        cq_valid;
    cmd_t        cq_head;
    logic        res_full;
    logic        res_push;
    dist_t       res_val;

    // front end: clamps indices, drops no-op loads, queues commands
    tdbl_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .node       (node),
        .other_node (other_node),
        .eng_status (eng_status),
        .cq_valid   (cq_valid),
        .cq_head    (cq_head)
    );

    // back end: owns depth and jump tables, one command at a time
    tdbl_engine #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cq_valid   (cq_valid),
        .cq_head    (cq_head),
        .eng_status (eng_status),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_val    (res_val)
    );

    // result side queue decouples consumer stalls from the engine
    tdbl_result_q u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_val  (res_val),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .distance (distance)
    );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: tree distance unit testbench
// Builds random trees through load transactions, queries path lengths and
// checks each returned distance against a behavioural binary lifting model.
// ----------------------------------------------------------------------------

// Mirror of the node tables; works out the expected distance for each query.
class distance_scoreboard;
    logic [9:0] depth_mem [1024];
    logic [9:0] jump_mem [1024][10];
    logic [10:0] pending_dist [$];

    function void clear_tables();
        foreach (depth_mem[i])
        begin
            depth_mem[i] = '0;
            for (int k = 0; k < 10; k++)
                jump_mem[i][k] = '0;
        end
        pending_dist.delete();
    endfunction

    function logic [10:0] path_length(logic [9:0] a, logic [9:0] b);
        logic [9:0] t;
        int diff;
        int count;
        if (depth_mem[a] > depth_mem[b])
        begin
            t = a;
            a = b;
            b = t;
        end
        diff = depth_mem[b] - depth_mem[a];
        count = diff;
        for (int k = 9; k >= 0; k--)
            if (diff[k])
                b = jump_mem[b][k];
        if (a == b)
            return 11'(count);
        for (int k = 9; k >= 0; k--)
            if (jump_mem[a][k] != jump_mem[b][k])
            begin
                count += 2 << k;
                a = jump_mem[a][k];
                b = jump_mem[b][k];
            end
        count += 2;
        return (count > 2047) ? 11'd2047 : 11'(count);
    endfunction

    // Accepted command transaction.
    function void note_command(logic is_q, logic [9:0] n, logic [9:0] p);
        if (is_q)
            pending_dist = {pending_dist, path_length(n, p)};
        else if (n != 0)
        begin
            depth_mem[n] = (depth_mem[p] == 10'h3FF) ? 10'h3FF : depth_mem[p] + 10'd1;
            jump_mem[n][0] = p;
            for (int k = 1; k < 10; k++)
                jump_mem[n][k] = jump_mem[jump_mem[n][k-1]][k-1];
        end
    endfunction

    // Accepted result transaction; returns 1 when it matches.
    function bit check_result(logic [10:0] got, output logic [10:0] want);
        want = 'x;
        if (pending_dist.size() == 0)
            return 0;
        want = pending_dist.pop_front();
        return got === want;
    endfunction
endclass

module tb
    import tdbl_pkg::*;
;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic              cmd = 1'b0;
    logic [NODE_W-1:0] node = '0;
    logic [NODE_W-1:0] other_node = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [DIST_W-1:0] distance;

    distance_scoreboard sb = new();
    int  err_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  stall_cycles = 0;
    // nodes already loaded in the current tree, used to pick parents
    logic [9:0] tree_nodes [$];

    tree_distance_binary_lifting_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .node(node), .other_node(other_node), .empty(empty), .pop(pop),
        .distance(distance)
    );

    always #5 clk = ~clk;

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // One command transaction; random gaps before it per the sender idle rate.
    // Called at a falling edge; push stays high until the next idle or drain.
    task automatic send_command(logic is_q, logic [9:0] n, logic [9:0] p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        cmd <= is_q;
        node <= n;
        other_node <= p;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_command(is_q, n, p);
        @(negedge clk);
    endtask

    task automatic load_node(logic [9:0] n, logic [9:0] p);
        send_command(1'b0, n, p);
    endtask

    task automatic query(logic [9:0] a, logic [9:0] b);
        send_command(1'b1, a, b);
    endtask

    function automatic logic [9:0] pick_node();
        if (tree_nodes.size() == 0 || $urandom_range(9) == 0)
            return 10'($urandom_range(1023));
        return tree_nodes[$urandom_range(tree_nodes.size() - 1)];
    endfunction

    // Result side: pop at random, check on every accepted transaction.
    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        logic [10:0] want;
        if (rst_n && pop && !empty)
        begin
            if (!sb.check_result(distance, want))
                report($sformatf("distance got %0d expected %0d", distance, want));
        end
    end

    // Watchdog over cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000)
        begin
            $display("FAIL tree_distance_binary_lifting_unit");
            $finish;
        end
    end

    // Random tree build: mostly well-formed loads mixed at random with queries.
    task automatic random_phase(int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(99) < 45)
            begin
                logic [9:0] n;
                logic [9:0] p;
                n = 10'($urandom_range(1023));
                if ($urandom_range(19) == 0)
                    p = 10'($urandom_range(1023));   // broken order / noise parent
                else if (tree_nodes.size() == 0)
                    p = 10'd1;
                else
                    p = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
                load_node(n, p);
                if (n != 0)
                    tree_nodes = {tree_nodes, n};
            end
            else
                query(pick_node(), pick_node());
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending_dist.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    initial
    begin
        sb.clear_tables();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: deep chain, branches, equal nodes, sentinel, extremes
        load_node(10'd1, 10'd0);
        tree_nodes = {tree_nodes, 10'd1};
        for (int i = 2; i <= 12; i++)
            load_node(10'(i), 10'(i - 1));
        load_node(10'd1023, 10'd1);
        load_node(10'd0, 10'd5);            // sentinel load, ignored
        load_node(10'd1022, 10'd1023);
        query(10'd12, 10'd12);              // same node
        query(10'd12, 10'd1);               // ancestor
        query(10'd3, 10'd12);               // non-parent ancestor, swapped
        query(10'd12, 10'd1022);            // across branches
        query(10'd0, 10'd1023);             // sentinel
        query(10'd1023, 10'd0);
        query(10'd500, 10'd7);              // unloaded node
        query(10'd0, 10'd0);
        drain();                            // sender pauses until all results are in

        tree_nodes.delete();
        tree_nodes = {tree_nodes, 10'd1};

        send_idle_pct = 16;
        recv_idle_pct = 86;
        random_phase(500);
        send_idle_pct = 86;
        recv_idle_pct = 16;
        random_phase(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(530);

        drain();
        if (err_count == 0 && sb.pending_dist.size() == 0)
            $display("PASS tree_distance_binary_lifting_unit");
        else
            $display("FAIL tree_distance_binary_lifting_unit");
        $finish;
    end
endmodule
